>>> sv/sfrs_pkg.sv
package sfrs_pkg;

  // Store depth, register reset values and the idle reply byte
  localparam int unsigned FRAME_DEPTH_DEF   = 256;
  localparam logic [31:0] GAP_TICKS_RST     = 32'd10;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;
  localparam logic [7:0]  REPLY_IDLE        = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_GAP_TICKS     = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_LOAD   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STATUS_IDLE    = 3'd0,
    STATUS_GAP     = 3'd1,
    STATUS_WAIT    = 3'd2,
    STATUS_TIMEOUT = 3'd3,
    STATUS_DONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_START   = 2'd1,
    FAULT_TIMEOUT = 2'd2
  } fault_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_GAP     = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_TIMEOUT = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] tick;
    logic [8:0]  frame_length;
    logic [7:0]  byte_slot;
    logic [7:0]  byte_value;
    logic        start_ok;
    logic        rx_done;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_idle;
    logic        tx_start;
    logic [31:0] frames_sent;
    logic [31:0] bytes_sent;
    logic [31:0] idle_replies;
    logic [31:0] other_replies;
    logic [31:0] start_fail_count;
    logic [31:0] timeout_count;
    logic [1:0]  last_fault;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
    logic        index;
  } cfg_t;

  // Map the one-hot phase onto the reported status code
  function automatic logic [2:0] phase_status(input phase_t ph);
    logic [2:0] s;
    case (ph)
      PH_IDLE:    s = STATUS_IDLE;
      PH_GAP:     s = STATUS_GAP;
      PH_WAIT:    s = STATUS_WAIT;
      PH_TIMEOUT: s = STATUS_TIMEOUT;
      PH_DONE:    s = STATUS_DONE;
      default:    s = STATUS_IDLE;
    endcase
    return s;
  endfunction

endpackage

>>> sv/sfrs_in_if.sv
interface sfrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] tick;
  logic [8:0]  frame_length;
  logic [7:0]  byte_slot;
  logic [7:0]  byte_value;
  logic        start_ok;
  logic        rx_done;
  logic [7:0]  rx_byte;

  modport source (
    output valid, mode, tick, frame_length, byte_slot, byte_value,
           start_ok, rx_done, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, tick, frame_length, byte_slot, byte_value,
           start_ok, rx_done, rx_byte,
    output ready
  );
endinterface

>>> sv/sfrs_out_if.sv
interface sfrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_idle;
  logic        tx_start;
  logic [7:0]  tx_byte;
  logic [31:0] frames_sent;
  logic [31:0] bytes_sent;
  logic [31:0] idle_replies;
  logic [31:0] other_replies;
  logic [31:0] start_fail_count;
  logic [31:0] timeout_count;
  logic [1:0]  last_fault;

  modport source (
    output valid, status, is_idle, tx_start, tx_byte, frames_sent, bytes_sent,
           idle_replies, other_replies, start_fail_count, timeout_count,
           last_fault,
    input  ready
  );
  modport sink (
    input  valid, status, is_idle, tx_start, tx_byte, frames_sent, bytes_sent,
           idle_replies, other_replies, start_fail_count, timeout_count,
           last_fault,
    output ready
  );
endinterface

>>> sv/sfrs_ram.sv
module sfrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sfrs_core.sv
module sfrs_core #(
  parameter int unsigned FRAME_DEPTH = sfrs_pkg::FRAME_DEPTH_DEF,
  localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfrs_pkg::cfg_t    cfg,
  input  logic              fire,
  input  sfrs_pkg::item_t   item,
  output sfrs_pkg::result_t res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [7:0]        mem_wdata,
  output logic [AW-1:0]     mem_raddr
);

  sfrs_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] gap_ticks_r, timeout_ticks_r;
  logic [8:0]  frame_len_r, frame_len_nxt;
  logic [8:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] gap_ref_r, gap_ref_nxt;
  logic [31:0] start_tick_r, start_tick_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [31:0] idle_rep_r, idle_rep_nxt;
  logic [31:0] other_rep_r, other_rep_nxt;
  logic [31:0] start_fail_r, start_fail_nxt;
  logic [31:0] timeouts_r, timeouts_nxt;
  logic [1:0]  fault_r, fault_nxt;
  logic        tx_start;
  logic [8:0]  pos_inc;
  logic [8:0]  len_clamped;

  assign pos_inc     = byte_pos_r + 9'd1;
  assign len_clamped = (32'(item.frame_length) > 32'(FRAME_DEPTH)) ?
                       9'(FRAME_DEPTH) : item.frame_length;

  // Store access: load bytes go straight in, sends read at the current position
  assign mem_we    = fire && (item.mode == sfrs_pkg::MODE_LOAD) &&
                     (32'(item.byte_slot) < 32'(FRAME_DEPTH));
  assign mem_waddr = AW'(item.byte_slot);
  assign mem_wdata = item.byte_value;
  assign mem_raddr = AW'(byte_pos_r);

  // Sequence one transaction against the current state
  always_comb begin
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    byte_pos_nxt   = byte_pos_r;
    gap_ref_nxt    = gap_ref_r;
    start_tick_nxt = start_tick_r;
    frames_nxt     = frames_r;
    bytes_nxt      = bytes_r;
    idle_rep_nxt   = idle_rep_r;
    other_rep_nxt  = other_rep_r;
    start_fail_nxt = start_fail_r;
    timeouts_nxt   = timeouts_r;
    fault_nxt      = fault_r;
    tx_start       = 1'b0;
    case (item.mode)
      sfrs_pkg::MODE_LOAD: begin
      end
      sfrs_pkg::MODE_FINISH: begin
        frame_len_nxt = '0;
        byte_pos_nxt  = '0;
        phase_nxt     = sfrs_pkg::PH_IDLE;
      end
      sfrs_pkg::MODE_START: begin
        if (phase_r == sfrs_pkg::PH_IDLE && item.frame_length != 9'd0) begin
          frame_len_nxt = len_clamped;
          byte_pos_nxt  = '0;
          gap_ref_nxt   = item.tick - gap_ticks_r;
          phase_nxt     = sfrs_pkg::PH_GAP;
        end
      end
      sfrs_pkg::MODE_TICK: begin
        if (phase_r == sfrs_pkg::PH_GAP) begin
          if ((item.tick - gap_ref_r) >= gap_ticks_r) begin
            tx_start = 1'b1;
            if (!item.start_ok) begin
              start_fail_nxt = start_fail_r + 32'd1;
              fault_nxt      = sfrs_pkg::FAULT_START;
              phase_nxt      = sfrs_pkg::PH_TIMEOUT;
            end else begin
              start_tick_nxt = item.tick;
              phase_nxt      = sfrs_pkg::PH_WAIT;
            end
          end
        end else if (phase_r == sfrs_pkg::PH_WAIT) begin
          if ((item.tick - start_tick_r) >= timeout_ticks_r) begin
            timeouts_nxt = timeouts_r + 32'd1;
            fault_nxt    = sfrs_pkg::FAULT_TIMEOUT;
            phase_nxt    = sfrs_pkg::PH_TIMEOUT;
          end else if (item.rx_done) begin
            if (item.rx_byte == sfrs_pkg::REPLY_IDLE) begin
              idle_rep_nxt = idle_rep_r + 32'd1;
            end else begin
              other_rep_nxt = other_rep_r + 32'd1;
            end
            bytes_nxt    = bytes_r + 32'd1;
            byte_pos_nxt = pos_inc;
            if (pos_inc >= frame_len_r) begin
              frames_nxt = frames_r + 32'd1;
              phase_nxt  = sfrs_pkg::PH_DONE;
            end else begin
              gap_ref_nxt = item.tick;
              phase_nxt   = sfrs_pkg::PH_GAP;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result as seen after the transaction
  always_comb begin
    res.status           = sfrs_pkg::phase_status(phase_nxt);
    res.is_idle          = (phase_nxt == sfrs_pkg::PH_IDLE);
    res.tx_start         = tx_start;
    res.frames_sent      = frames_nxt;
    res.bytes_sent       = bytes_nxt;
    res.idle_replies     = idle_rep_nxt;
    res.other_replies    = other_rep_nxt;
    res.start_fail_count = start_fail_nxt;
    res.timeout_count    = timeouts_nxt;
    res.last_fault       = fault_nxt;
  end

  // Hold configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r     <= sfrs_pkg::GAP_TICKS_RST;
      timeout_ticks_r <= sfrs_pkg::TIMEOUT_TICKS_RST;
      phase_r         <= sfrs_pkg::PH_IDLE;
      frame_len_r     <= '0;
      byte_pos_r      <= '0;
      gap_ref_r       <= '0;
      start_tick_r    <= '0;
      frames_r        <= '0;
      bytes_r         <= '0;
      idle_rep_r      <= '0;
      other_rep_r     <= '0;
      start_fail_r    <= '0;
      timeouts_r      <= '0;
      fault_r         <= sfrs_pkg::FAULT_NONE;
    end else begin
      if (cfg.we) begin
        if (cfg.index == sfrs_pkg::CFG_GAP_TICKS) begin
          gap_ticks_r <= cfg.wdata;
        end else begin
          timeout_ticks_r <= cfg.wdata;
        end
      end
      if (fire) begin
        phase_r      <= phase_nxt;
        frame_len_r  <= frame_len_nxt;
        byte_pos_r   <= byte_pos_nxt;
        gap_ref_r    <= gap_ref_nxt;
        start_tick_r <= start_tick_nxt;
        frames_r     <= frames_nxt;
        bytes_r      <= bytes_nxt;
        idle_rep_r   <= idle_rep_nxt;
        other_rep_r  <= other_rep_nxt;
        start_fail_r <= start_fail_nxt;
        timeouts_r   <= timeouts_nxt;
        fault_r      <= fault_nxt;
      end
    end
  end

endmodule

>>> sv/spi_frame_request_sequencer.sv
// SPI frame request sequencer.
// Input channel in_chan carries one transaction per request: load a frame
// byte, start a frame, finish, or a service tick with the peripheral's
// start acknowledgement and receive completion. Every input transaction
// gives exactly one result transaction on out_chan with the status, the
// transmit request and byte, and the wrapping event counters.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the gap and the
// timeout in ticks; write them only while the block is idle.
// An accepted transaction is held in the input register; the result
// register, loaded together with the frame store's registered read,
// then offers its result. Throughput is one transaction per cycle while
// out_chan is ready; the sequencer state updates as each transaction
// fires, so back-to-back transactions never wait on each other.
// A stall on out_chan holds the result register and backs up through the
// input register to in_chan.ready; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers, clears the phase,
// counters and fault, and restores the register defaults. The frame store
// is not cleared; send only bytes that have been loaded.
module spi_frame_request_sequencer #(
  parameter int unsigned FRAME_DEPTH = sfrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sfrs_in_if.sink     in_chan,
  sfrs_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

  logic              in_vld_r, in_vld_nxt;
  sfrs_pkg::item_t   item_r;
  logic              out_vld_r, out_vld_nxt;
  sfrs_pkg::result_t res_r;
  sfrs_pkg::result_t res;
  sfrs_pkg::cfg_t    cfg;
  logic              fire;
  logic              in_acc;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  // Advance the input register whenever the result register can take over
  assign fire           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !in_vld_r || fire;
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.mode         <= in_chan.mode;
      item_r.tick         <= in_chan.tick;
      item_r.frame_length <= in_chan.frame_length;
      item_r.byte_slot    <= in_chan.byte_slot;
      item_r.byte_value   <= in_chan.byte_value;
      item_r.start_ok     <= in_chan.start_ok;
      item_r.rx_done      <= in_chan.rx_done;
      item_r.rx_byte      <= in_chan.rx_byte;
    end
  end

  sfrs_core #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item_r),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr)
  );

  sfrs_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (fire),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.status           = res_r.status;
  assign out_chan.is_idle          = res_r.is_idle;
  assign out_chan.tx_start         = res_r.tx_start;
  assign out_chan.tx_byte          = res_r.tx_start ? mem_rdata : 8'd0;
  assign out_chan.frames_sent      = res_r.frames_sent;
  assign out_chan.bytes_sent       = res_r.bytes_sent;
  assign out_chan.idle_replies     = res_r.idle_replies;
  assign out_chan.other_replies    = res_r.other_replies;
  assign out_chan.start_fail_count = res_r.start_fail_count;
  assign out_chan.timeout_count    = res_r.timeout_count;
  assign out_chan.last_fault       = res_r.last_fault;

endmodule
